### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion helpers. They expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on clk and disabled during reset.
`define LMCF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define LMCF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define LMCF_ASSERT_IMP(lbl, ante, cons)
`define LMCF_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### hw/rtl/lmcf_pkg.sv
// ----------------------------------------------------------------------------
// LED matrix chain framebuffer package
// Sizes, operation codes, driver register addresses and the command and
// status structs shared by the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lmcf_pkg;

    // Chain length and framebuffer height.
    localparam int CHIPS       = 4;
    localparam int ROWS        = 8;
    localparam int STORE_BYTES = CHIPS * ROWS;
    localparam int IDX_W       = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    // Fixed field widths.
    localparam int OP_W      = 3;
    localparam int X_W       = 8;
    localparam int Y_W       = 4;
    localparam int DATA_W    = 8;
    localparam int SHIFT_W   = 3;
    localparam int ADDR_W    = 4;
    localparam int CHIP_W    = 3;
    localparam int FRAME_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int LIN_W     = 8;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PIXEL   = 3'd0;
    localparam logic [OP_W-1:0] OP_FILL    = 3'd1;
    localparam logic [OP_W-1:0] OP_REFRESH = 3'd2;
    localparam logic [OP_W-1:0] OP_INIT    = 3'd3;
    localparam logic [OP_W-1:0] OP_BLANK   = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DECODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT = 2'd2;

    // Driver register addresses.
    localparam logic [ADDR_W-1:0] ADDR_DIGIT0 = 4'h1;
    localparam logic [ADDR_W-1:0] ADDR_DECODE = 4'h9;
    localparam logic [ADDR_W-1:0] ADDR_INTENS = 4'hA;
    localparam logic [ADDR_W-1:0] ADDR_SCAN   = 4'hB;
    localparam logic [ADDR_W-1:0] ADDR_SHUT   = 4'hC;

    localparam logic [DATA_W-1:0] SHUT_NORMAL = 8'h01;

    // Frame sequence: four setup frames, then one digit frame per row.
    localparam logic [FRAME_W-1:0] FR_DECODE    = 4'd0;
    localparam logic [FRAME_W-1:0] FR_SCAN      = 4'd1;
    localparam logic [FRAME_W-1:0] FR_INTENS    = 4'd2;
    localparam logic [FRAME_W-1:0] FR_SHUT      = 4'd3;
    localparam logic [FRAME_W-1:0] SETUP_FRAMES = 4'd4;

    // Reset values of the configuration registers.
    localparam logic [7:0] DECODE_RST = 8'd0;
    localparam logic [2:0] SCAN_RST   = 3'd7;
    localparam logic [3:0] BRIGHT_RST = 4'd1;

    typedef struct packed {
        logic                 pix_wr;
        logic                 fill;
        logic                 start;
        logic                 load_cur;
        logic                 emit;
        logic                 refresh;
        logic                 end_frame;
        logic                 last;
        logic [FRAME_W-1:0]   frame;
        logic [CHIP_W-1:0]    chip;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

### hw/rtl/lmcf_ctrl.sv
// ----------------------------------------------------------------------------
// LED matrix chain framebuffer controller
// Accepts items, decodes the operation and steps through frames and chips
// while the datapath produces command words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module lmcf_ctrl
    import lmcf_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [OP_W-1:0] op,
    input  status_t         status,
    output cmd_t            cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [CHIP_W-1:0]  chip_reg, chip_next;
    logic               refresh_reg, refresh_next;
    logic               end_frame;
    logic               last_frame;

    assign in_stall   = (state_reg != ST_IDLE);
    assign end_frame  = (chip_reg == CHIP_W'(CHIPS - 1));
    assign last_frame = (frame_reg == FRAME_W'(ROWS + 3));

    always_comb
    begin
        state_next    = state_reg;
        frame_next    = frame_reg;
        chip_next     = chip_reg;
        refresh_next  = refresh_reg;
        cmd           = '0;
        cmd.frame     = frame_reg;
        cmd.chip      = chip_reg;
        cmd.refresh   = refresh_reg;
        cmd.end_frame = end_frame;
        cmd.last      = end_frame && last_frame;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    chip_next = '0;
                    case (op)
                        OP_PIXEL:
                        begin
                            cmd.pix_wr = 1'b1;
                        end
                        OP_FILL:
                        begin
                            cmd.fill = 1'b1;
                        end
                        OP_REFRESH:
                        begin
                            cmd.start    = 1'b1;
                            refresh_next = 1'b1;
                            frame_next   = SETUP_FRAMES;
                            state_next   = ST_LOAD;
                        end
                        OP_INIT:
                        begin
                            cmd.start    = 1'b1;
                            refresh_next = 1'b0;
                            frame_next   = FR_DECODE;
                            state_next   = ST_EMIT;
                        end
                        OP_BLANK:
                        begin
                            cmd.start    = 1'b1;
                            refresh_next = 1'b0;
                            frame_next   = SETUP_FRAMES;
                            state_next   = ST_EMIT;
                        end
                        default:
                        begin
                            // Unknown operations are taken and dropped.
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                // Fetch the first byte of the row before its words go out.
                cmd.load_cur = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (end_frame)
                    begin
                        chip_next = '0;
                        if (last_frame)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            frame_next = frame_reg + 1'b1;
                            state_next = refresh_reg ? ST_LOAD : ST_EMIT;
                        end
                    end
                    else
                    begin
                        chip_next = chip_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            frame_reg   <= '0;
            chip_reg    <= '0;
            refresh_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            frame_reg   <= frame_next;
            chip_reg    <= chip_next;
            refresh_reg <= refresh_next;
        end
    end

    `LMCF_ASSERT_NXT(a_load_then_emit, state_reg == ST_LOAD, state_reg == ST_EMIT)
    `LMCF_ASSERT_NXT(a_last_to_idle, cmd.emit && cmd.last, state_reg == ST_IDLE)
    `LMCF_ASSERT_IMP(a_chip_in_range, state_reg == ST_EMIT, chip_reg <= CHIP_W'(CHIPS - 1))
    `LMCF_ASSERT_NXT(a_refresh_starts_load, !in_stall && in_valid && op == OP_REFRESH,
                     state_reg == ST_LOAD)

endmodule

### hw/rtl/lmcf_datapath.sv
// ----------------------------------------------------------------------------
// LED matrix chain framebuffer datapath
// Framebuffer store, configuration registers, row byte shifter and the
// output word register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lmcf_datapath
    import lmcf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output status_t              status,
    input  logic [X_W-1:0]       pixel_x,
    input  logic [Y_W-1:0]       pixel_y,
    input  logic [DATA_W-1:0]    data_value,
    input  logic [SHIFT_W-1:0]   bit_offset,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [ADDR_W-1:0]    reg_addr,
    output logic [DATA_W-1:0]    cmd_data,
    output logic [CHIP_W-1:0]    chip_index,
    output logic                 end_of_frame,
    output logic                 last
);

    logic [DATA_W-1:0]  store_reg [STORE_BYTES];
    logic [7:0]         decode_reg;
    logic [2:0]         scan_reg;
    logic [3:0]         bright_reg;
    logic [DATA_W-1:0]  dv_reg;
    logic [SHIFT_W-1:0] sh_reg;
    logic [DATA_W-1:0]  cur_reg;

    logic               out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]  addr_reg;
    logic [DATA_W-1:0]  data_reg;
    logic [CHIP_W-1:0]  chip_reg;
    logic               eof_reg;
    logic               last_reg;

    logic [FRAME_W-1:0] row;
    logic [LIN_W-1:0]   row_base;
    logic [LIN_W-1:0]   lin;
    logic [DATA_W-1:0]  rd_data;
    logic               pix_ok;
    logic [DATA_W-1:0]  pix_mask;
    logic [DATA_W-1:0]  pix_byte;
    logic [DATA_W-1:0]  nxt;
    logic [2*DATA_W-1:0] pair_shifted;
    logic [ADDR_W-1:0]  word_addr;
    logic [DATA_W-1:0]  word_data;

    assign status.out_free = !out_valid_reg || !out_stall;

    // One read address per cycle: pixel byte, first byte of a row, or the
    // byte to the right of the current word.
    assign row      = cmd.frame - SETUP_FRAMES;
    assign row_base = LIN_W'(row) * LIN_W'(CHIPS);

    always_comb
    begin
        if (cmd.pix_wr)
        begin
            lin = LIN_W'(pixel_y) * LIN_W'(CHIPS) + LIN_W'(pixel_x[X_W-1:3]);
        end
        else if (cmd.load_cur)
        begin
            lin = row_base;
        end
        else
        begin
            lin = row_base + LIN_W'(cmd.chip) + 1'b1;
        end
    end

    assign rd_data = (lin < LIN_W'(STORE_BYTES)) ? store_reg[lin[IDX_W-1:0]] : '0;

    assign pix_ok   = (pixel_x < X_W'(CHIPS * 8)) && (pixel_y < Y_W'(ROWS));
    assign pix_mask = 8'h80 >> pixel_x[2:0];
    assign pix_byte = data_value[0] ? (rd_data | pix_mask) : (rd_data & ~pix_mask);

    // Past the end of the row the neighbor byte counts as zero.
    assign nxt          = cmd.end_frame ? '0 : rd_data;
    assign pair_shifted = {cur_reg, nxt} << sh_reg;

    always_comb
    begin
        case (cmd.frame)
            FR_DECODE:
            begin
                word_addr = ADDR_DECODE;
                word_data = decode_reg;
            end
            FR_SCAN:
            begin
                word_addr = ADDR_SCAN;
                word_data = {5'd0, scan_reg};
            end
            FR_INTENS:
            begin
                word_addr = ADDR_INTENS;
                word_data = {4'd0, bright_reg};
            end
            FR_SHUT:
            begin
                word_addr = ADDR_SHUT;
                word_data = SHUT_NORMAL;
            end
            default:
            begin
                word_addr = ADDR_DIGIT0 + row;
                word_data = cmd.refresh ? pair_shifted[2*DATA_W-1:DATA_W] : dv_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_BYTES; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (cmd.fill)
        begin
            for (int i = 0; i < STORE_BYTES; i++)
            begin
                store_reg[i] <= data_value;
            end
        end
        else if (cmd.pix_wr && pix_ok)
        begin
            store_reg[lin[IDX_W-1:0]] <= pix_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_reg <= DECODE_RST;
            scan_reg   <= SCAN_RST;
            bright_reg <= BRIGHT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_DECODE: decode_reg <= cfg_data;
                CFG_SCAN:   scan_reg   <= cfg_data[2:0];
                CFG_BRIGHT: bright_reg <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    // Item operands and the running row byte.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            dv_reg <= data_value;
            sh_reg <= bit_offset;
        end
        if (cmd.load_cur || (cmd.emit && cmd.refresh))
        begin
            cur_reg <= rd_data;
        end
    end

    assign out_valid_next = cmd.emit ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            addr_reg <= word_addr;
            data_reg <= word_data;
            chip_reg <= cmd.chip;
            eof_reg  <= cmd.end_frame;
            last_reg <= cmd.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign reg_addr     = addr_reg;
    assign cmd_data     = data_reg;
    assign chip_index   = chip_reg;
    assign end_of_frame = eof_reg;
    assign last         = last_reg;

endmodule

### hw/rtl/led_matrix_chain_framebuffer.sv
// ----------------------------------------------------------------------------
// LED matrix chain framebuffer
// Monochrome framebuffer for a chain of 8x8 LED matrix drivers that turns
// refresh, init and blank requests into framed driver command words.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake              Payload
//   in        input       in_valid / in_stall    op, pixel_x, pixel_y,
//                                                data_value, bit_offset
//   out       output      out_valid / out_stall  reg_addr, cmd_data, chip_index,
//                                                end_of_frame, last
//   cfg       input       cfg_wr_en              cfg_index, cfg_data
//
// Pixel writes, fills and unknown operations never stall the input, so they
// can arrive back to back. Init and blank stall the input until their last
// command word goes out, (ROWS + 4) * CHIPS and ROWS * CHIPS words; refresh
// also reads the first byte of each row before its words, ROWS * CHIPS words
// in all. A stalled output holds the word generator until the output
// register frees. Reset clears the store and sets the configuration
// registers to their reset values at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_matrix_chain_framebuffer
    import lmcf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [OP_W-1:0]      op,
    input  logic [X_W-1:0]       pixel_x,
    input  logic [Y_W-1:0]       pixel_y,
    input  logic [DATA_W-1:0]    data_value,
    input  logic [SHIFT_W-1:0]   bit_offset,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [ADDR_W-1:0]    reg_addr,
    output logic [DATA_W-1:0]    cmd_data,
    output logic [CHIP_W-1:0]    chip_index,
    output logic                 end_of_frame,
    output logic                 last,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    cmd_t    cmd;
    status_t status;

    lmcf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .status   (status),
        .cmd      (cmd)
    );

    lmcf_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .data_value   (data_value),
        .bit_offset   (bit_offset),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .reg_addr     (reg_addr),
        .cmd_data     (cmd_data),
        .chip_index   (chip_index),
        .end_of_frame (end_of_frame),
        .last         (last)
    );

endmodule

### tb/led_matrix_chain_framebuffer_tb.sv
// ----------------------------------------------------------------------------
// LED matrix chain framebuffer testbench
// Drives pixel writes, fills, refresh, init, blank and unknown requests with random
// idling on both channels, keeps a shadow framebuffer and configuration, and
// checks every driver command word against the words the shadow predicts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_matrix_chain_framebuffer_tb;
    import lmcf_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 60;

    // Operation codes and a register index that the block does not define.
    localparam logic [OP_W-1:0]      OP_RSVD_LO = 3'd5;
    localparam logic [OP_W-1:0]      OP_RSVD_HI = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_RSVD   = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [CHIP_W-1:0] chip;
        logic              eof;
        logic              last;
    } drv_word_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [OP_W-1:0]      op = OP_PIXEL;
    logic [X_W-1:0]       pixel_x = '0;
    logic [Y_W-1:0]       pixel_y = '0;
    logic [DATA_W-1:0]    data_value = '0;
    logic [SHIFT_W-1:0]   bit_offset = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [ADDR_W-1:0]    reg_addr;
    logic [DATA_W-1:0]    cmd_data;
    logic [CHIP_W-1:0]    chip_index;
    logic                 end_of_frame;
    logic                 last;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_DECODE;
    logic [7:0]           cfg_data = '0;

    // Shadow copy of the framebuffer and the configuration registers.
    logic [DATA_W-1:0] shadow_fb [STORE_BYTES];
    logic [7:0]        decode_reg = DECODE_RST;
    logic [2:0]        scan_reg   = SCAN_RST;
    logic [3:0]        bright_reg = BRIGHT_RST;

    drv_word_t pending_words[$];

    int  errors = 0;
    int  items_sent = 0;
    int  words_seen = 0;
    int  op_count [8];
    bit  tx_gaps = 1'b1;
    bit  rx_gaps = 1'b1;
    int  hold_request = 0;
    int  hold_count = 0;

    led_matrix_chain_framebuffer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .data_value   (data_value),
        .bit_offset   (bit_offset),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .reg_addr     (reg_addr),
        .cmd_data     (cmd_data),
        .chip_index   (chip_index),
        .end_of_frame (end_of_frame),
        .last         (last),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Command word prediction
    // ------------------------------------------------------------------
    function automatic void queue_word(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d,
                                       input int chip);
        drv_word_t w;
        w.addr = a;
        w.data = d;
        w.chip = chip[CHIP_W-1:0];
        w.eof  = (chip == CHIPS - 1);
        w.last = 1'b0;
        pending_words.push_back(w);
    endfunction

    function automatic void queue_uniform(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
        for (int c = 0; c < CHIPS; c++)
        begin
            queue_word(a, d, c);
        end
    endfunction

    function automatic void queue_digits(input logic [DATA_W-1:0] d);
        for (int r = 0; r < ROWS; r++)
        begin
            queue_uniform(ADDR_DIGIT0 + ADDR_W'(r), d);
        end
    endfunction

    // Applies one accepted item to the shadow state and queues the words it sends.
    function automatic void predict_commands(input logic [OP_W-1:0] o, input logic [X_W-1:0] x,
                                             input logic [Y_W-1:0] y,
                                             input logic [DATA_W-1:0] dv,
                                             input logic [SHIFT_W-1:0] sh);
        int          prior_words;
        int          px;
        int          base;
        logic [15:0] pair;
        drv_word_t   w;
        prior_words = pending_words.size();
        px = int'(x);
        case (o)
            OP_PIXEL:
            begin
                if (px < CHIPS * 8 && y < ROWS)
                begin
                    shadow_fb[y * CHIPS + px / 8][7 - px % 8] = dv[0];
                end
            end
            OP_FILL:
            begin
                foreach (shadow_fb[i])
                begin
                    shadow_fb[i] = dv;
                end
            end
            OP_REFRESH:
            begin
                for (int r = 0; r < ROWS; r++)
                begin
                    base = r * CHIPS;
                    for (int c = 0; c < CHIPS; c++)
                    begin
                        // The byte to the right feeds the vacated low bits; zero past the end.
                        pair = {shadow_fb[base + c],
                                (c + 1 < CHIPS) ? shadow_fb[base + c + 1] : 8'h00} << sh;
                        queue_word(ADDR_DIGIT0 + ADDR_W'(r), pair[15:8], c);
                    end
                end
            end
            OP_INIT:
            begin
                queue_uniform(ADDR_DECODE, decode_reg);
                queue_uniform(ADDR_SCAN, {5'b0, scan_reg});
                queue_uniform(ADDR_INTENS, {4'b0, bright_reg});
                queue_uniform(ADDR_SHUT, SHUT_NORMAL);
                queue_digits(dv);
            end
            OP_BLANK:
            begin
                queue_digits(dv);
            end
            default:
            begin
            end
        endcase
        if (pending_words.size() > prior_words)
        begin
            w = pending_words[pending_words.size() - 1];
            w.last = 1'b1;
            pending_words[pending_words.size() - 1] = w;
        end
    endfunction

    // ------------------------------------------------------------------
    // Output side: stall generation and word checking
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_count = hold_request;
            hold_request = 0;
        end
        if (hold_count > 0)
        begin
            out_stall <= 1'b1;
            hold_count = hold_count - 1;
        end
        else if (rx_gaps)
        begin
            out_stall <= ($urandom_range(0, 99) < 20);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
                                        input logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : check_word
        drv_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            words_seen++;
            if (pending_words.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected word, expected none, actual addr %0h data %0h",
                         $time, reg_addr, cmd_data);
            end
            else
            begin
                want = pending_words.pop_front();
                check_field("reg_addr", DATA_W'(want.addr), DATA_W'(reg_addr));
                check_field("cmd_data", want.data, cmd_data);
                check_field("chip_index", DATA_W'(want.chip), DATA_W'(chip_index));
                check_field("end_of_frame", DATA_W'(want.eof), DATA_W'(end_of_frame));
                check_field("last", DATA_W'(want.last), DATA_W'(last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    task automatic send_item(input logic [OP_W-1:0] o, input logic [X_W-1:0] x,
                             input logic [Y_W-1:0] y, input logic [DATA_W-1:0] dv,
                             input logic [SHIFT_W-1:0] sh);
        int gap;
        if (tx_gaps && $urandom_range(0, 99) < 20)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= o;
        pixel_x    <= x;
        pixel_y    <= y;
        data_value <= dv;
        bit_offset <= sh;
        do
            @(posedge clk);
        while (in_stall);
        predict_commands(o, x, y, dv, sh);
        items_sent++;
        op_count[o]++;
    endtask

    // Stops sending and waits until every predicted word has come out and the
    // block has had time to finish any store update still in flight.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            CFG_DECODE: decode_reg = value;
            CFG_SCAN:   scan_reg   = value[2:0];
            CFG_BRIGHT: bright_reg = value[3:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic configure(input logic [7:0] decode_v, input logic [7:0] scan_v,
                             input logic [7:0] bright_v);
        write_cfg(CFG_DECODE, decode_v);
        write_cfg(CFG_SCAN, scan_v);
        write_cfg(CFG_BRIGHT, bright_v);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_random_item();
        int                 pick;
        logic [OP_W-1:0]    o;
        logic [X_W-1:0]     x;
        logic [Y_W-1:0]     y;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            o = OP_PIXEL;
        else if (pick < 60)
            o = OP_FILL;
        else if (pick < 78)
            o = OP_REFRESH;
        else if (pick < 83)
            o = OP_INIT;
        else if (pick < 93)
            o = OP_BLANK;
        else
            o = OP_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
        // Most pixel writes land on the panel; the rest use the full field range.
        if ($urandom_range(0, 9) < 8)
        begin
            x = X_W'($urandom_range(0, CHIPS * 8 - 1));
            y = Y_W'($urandom_range(0, ROWS - 1));
        end
        else
        begin
            x = X_W'($urandom);
            y = Y_W'($urandom);
        end
        send_item(o, x, y, DATA_W'($urandom), SHIFT_W'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_values();
        send_item(OP_INIT, '0, '0, 8'h00, '0);
        send_item(OP_REFRESH, '0, '0, '0, 3'd0);
    endtask

    task automatic test_config_registers();
        drain();
        configure(8'hFF, 8'h07, 8'h0F);
        send_item(OP_INIT, '0, '0, 8'h81, '0);
        drain();
        // Upper bits beyond the register widths must be dropped.
        configure(8'h00, 8'hF8, 8'hF0);
        send_item(OP_INIT, '0, '0, 8'h7E, '0);
        drain();
        write_cfg(CFG_RSVD, 8'hFF);
        cfg_wr_en <= 1'b0;
        send_item(OP_INIT, '0, '0, 8'h3C, '0);
        drain();
        configure(DECODE_RST, 8'(SCAN_RST), 8'(BRIGHT_RST));
    endtask

    task automatic test_pixel_edges();
        send_item(OP_PIXEL, 8'd0, 4'd0, 8'h01, '0);
        send_item(OP_PIXEL, X_W'(CHIPS * 8 - 1), Y_W'(ROWS - 1), 8'hFF, '0);
        send_item(OP_PIXEL, X_W'(CHIPS * 8), 4'd0, 8'h01, '0);
        send_item(OP_PIXEL, 8'hFF, 4'hF, 8'hFF, '0);
        send_item(OP_PIXEL, 8'd0, Y_W'(ROWS), 8'h01, '0);
        send_item(OP_PIXEL, 8'd7, 4'd3, 8'h01, '0);
        send_item(OP_PIXEL, 8'd8, 4'd3, 8'h01, '0);
        send_item(OP_REFRESH, '0, '0, '0, 3'd0);
        send_item(OP_PIXEL, X_W'(CHIPS * 8 - 1), Y_W'(ROWS - 1), 8'hFE, '0);
        send_item(OP_REFRESH, '0, '0, '0, 3'd7);
    endtask

    task automatic test_ops_and_offsets();
        send_item(OP_RSVD_LO, 8'd1, 4'd1, 8'hFF, 3'd7);
        send_item(OP_RSVD_LO + 3'd1, 8'd2, 4'd2, 8'hFF, 3'd7);
        send_item(OP_RSVD_HI, 8'd3, 4'd3, 8'hFF, 3'd7);
        send_item(OP_FILL, '0, '0, 8'hA5, '0);
        send_item(OP_REFRESH, '0, '0, '0, 3'd3);
        send_item(OP_BLANK, '0, '0, 8'hFF, '0);
        send_item(OP_BLANK, '0, '0, 8'h00, '0);
        send_item(OP_FILL, '0, '0, 8'h00, '0);
        send_item(OP_PIXEL, 8'd12, 4'd5, 8'h01, '0);
        send_item(OP_REFRESH, '0, '0, '0, 3'd1);
    endtask

    // The receiver holds off long enough for the block to back up into its
    // input, then the sender waits for every word before going on.
    task automatic test_backpressure();
        drain();
        hold_request = HOLD_CYCLES;
        repeat (4) send_item(OP_REFRESH, '0, '0, '0, SHIFT_W'($urandom));
        repeat (3) send_random_item();
        drain();
    endtask

    task automatic test_random_traffic(input int n_items, input bit no_idle);
        drain();
        configure(8'($urandom), 8'($urandom), 8'($urandom));
        tx_gaps = !no_idle;
        rx_gaps = !no_idle;
        repeat (n_items) send_random_item();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    initial
    begin
        foreach (shadow_fb[i])
        begin
            shadow_fb[i] = '0;
        end
        foreach (op_count[i])
        begin
            op_count[i] = 0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_config_registers();
        test_pixel_edges();
        test_ops_and_offsets();
        test_backpressure();
        test_random_traffic(PHASE_ITEMS, 1'b0);
        test_random_traffic(PHASE_ITEMS, 1'b1);
        test_random_traffic(PHASE_ITEMS, 1'b0);
        test_random_traffic(PHASE_ITEMS, 1'b0);

        drain();
        $display("Sent %0d items: %0d pixel, %0d fill, %0d refresh, %0d init, %0d blank.",
                 items_sent, op_count[OP_PIXEL], op_count[OP_FILL], op_count[OP_REFRESH],
                 op_count[OP_INIT], op_count[OP_BLANK]);
        $display("Checked %0d command words across several register settings, %0d errors.",
                 words_seen, errors);
        if (errors == 0 && pending_words.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timed out with %0d words still expected.", pending_words.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
